@@ rtl/core/ddo_pkg.sv @@
// Shared constants, types and functions for the differential-drive odometry block.
package ddo_pkg;

  localparam int TICK_BITS    = 16;
  localparam int CORDIC_STEPS = 18;
  localparam int ATAN_ENTRIES = 24;
  localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int STEP_W = 5;

  localparam logic signed [19:0] PI_Q16     = 20'sd205887;
  localparam logic signed [19:0] TWO_PI_Q16 = 20'sd411775;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  // Angle reduction: 2*pi shifted up far enough to cover any heading sum below 2^41.
  localparam int          WRAP_SHIFT = 22;
  localparam logic [41:0] WRAP_TOP   = 42'(TWO_PI_Q16) << WRAP_SHIFT;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_LDPT   = 3'd1;
  localparam logic [2:0] REG_RDPT   = 3'd2;
  localparam logic [2:0] REG_LAPM   = 3'd3;
  localparam logic [2:0] REG_RAPM   = 3'd4;

  localparam logic CMD_TICKS = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Clip a 16-bit tick delta to the TICK_BITS range.
  function automatic logic signed [15:0] clip_ticks(input logic signed [15:0] v);
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    logic signed [32:0] w;
    hi = (33'sd1 <<< (TICK_BITS - 1)) - 33'sd1;
    lo = -(33'sd1 <<< (TICK_BITS - 1));
    w  = 33'(v);
    if (w > hi) return 16'(hi);
    if (w < lo) return 16'(lo);
    return v;
  endfunction

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;   // signed dividend
    logic        [26:0] den;   // positive divisor
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quo;   // rounded to nearest, ties away from zero
  } div_rsp_t;

endpackage

@@ rtl/core/ddo_div.sv @@
// Radix-2 restoring divider with round-half-away-from-zero result.
module ddo_div (
  input  logic              clk,
  input  logic              rst,
  input  ddo_pkg::div_req_t req,
  output ddo_pkg::div_rsp_t rsp
);

  logic        [63:0] rem;
  logic        [63:0] quo;
  logic        [63:0] dvd;
  logic        [26:0] den;
  logic               neg;
  logic        [6:0]  cnt;
  logic               busy;
  logic               done;
  logic        [64:0] trial;
  logic        [63:0] mag;

  assign mag   = req.num[63] ? 64'(-req.num) : 64'(req.num);
  assign trial = {rem, dvd[63]} - {38'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        neg  <= req.num[63];
        // magnitude plus half the divisor, as the rounding rule asks
        dvd  <= mag + 64'(req.den >> 1);
        den  <= req.den;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], dvd[63]};
          quo <= {quo[62:0], 1'b0};
        end
        dvd <= {dvd[62:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = neg ? -$signed(quo) : $signed(quo);

endmodule

@@ rtl/core/ddo_cordic.sv @@
// Iterative rotation-mode CORDIC giving Q30 cosine and sine of a Q16 angle.
module ddo_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [19:0]  angle,
  output logic                done,
  output logic signed [33:0]  cos_q30,
  output logic signed [33:0]  sin_q30
);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic               flip;
  logic               busy;
  logic [ddo_pkg::STEP_W-1:0] step;
  logic signed [33:0] z0;

  assign z0 = 34'(angle) <<< 14;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= ddo_pkg::GAIN_Q30;
        y    <= '0;
        if (z0 > ddo_pkg::HALF_PI_Q30) begin
          z <= z0 - ddo_pkg::PI_Q30; flip <= 1'b1;
        end else if (z0 < -ddo_pkg::HALF_PI_Q30) begin
          z <= z0 + ddo_pkg::PI_Q30; flip <= 1'b1;
        end else begin
          z <= z0; flip <= 1'b0;
        end
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          z <= z - ddo_pkg::atan_q30(step);
        end else begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          z <= z + ddo_pkg::atan_q30(step);
        end
        step <= step + 1'b1;
        if (step == ddo_pkg::STEP_W'(ddo_pkg::NSTEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_q30 = flip ? -x : x;
  assign sin_q30 = flip ? -y : y;

endmodule

@@ rtl/core/diff_drive_odometry.sv @@
// Top level of the differential-drive wheel odometry block.
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per event:
//   cmd=0 is a tick update (left/right tick deltas and elapsed ms), cmd=1
//   zeroes the pose. Output channel (out_valid/out_ready) returns exactly one
//   transaction per input with the pose, velocities and pose_updated.
//   Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle
//   by the user; the block itself does not enforce this.
// Sequence:
//   Reset commands, disabled items and zero-tick items go straight to the
//   output state, which then raises out_valid. A tick update runs products
//   and rounding, reduction of the midpoint angle, the CORDIC (18 steps),
//   the x/y update, reduction of the new heading, then one division each
//   for speed and turn rate, before raising out_valid. The next input is
//   taken only after the previous result has left.
//   One transaction is in flight at a time; in_ready is low meanwhile.
// Stalls: the result sits in the output register until taken; in_ready
//   rises the cycle after the result leaves, so a stalled receiver holds
//   the block.
// Reset: synchronous, active high; clears pose, velocities and configuration registers.
module diff_drive_odometry (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic signed [15:0] left_ticks,
  input  logic signed [15:0] right_ticks,
  input  logic [15:0]        elapsed_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [18:0] heading,
  output logic signed [31:0] speed,
  output logic signed [31:0] turn_rate,
  output logic               pose_updated
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_ANG, S_HALF, S_WMID, S_CORD, S_POS, S_WHDG,
    S_DIVS, S_DIVT, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic        enable;
  logic [23:0] ldpt, rdpt, lapm, rapm;

  // state
  logic signed [31:0] x_acc, y_acc, speed_reg, turn_rate_reg;
  logic signed [18:0] heading_acc;

  // work registers
  logic signed [15:0] lt, rt;
  logic [26:0]        dt;
  logic signed [41:0] dl, dr;
  logic signed [33:0] dl16, dr16;
  logic signed [63:0] ang32;
  logic signed [33:0] dist_q16;
  logic signed [41:0] dang;
  logic signed [19:0] mid;

  // angle reduction by repeated compare and subtract of 2*pi << k
  logic        [41:0] wacc;
  logic        [41:0] wdiv;
  logic        [4:0]  wstep;
  logic               wneg;
  logic signed [47:0] wsrc;
  logic        [47:0] wmag;
  logic        [41:0] wacc_next;

  ddo_pkg::div_req_t dreq;
  ddo_pkg::div_rsp_t drsp;
  logic              cstart;
  logic              cdone;
  logic signed [33:0] cc, cs;

  ddo_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .angle(mid),
    .done(cdone), .cos_q30(cc), .sin_q30(cs)
  );

  ddo_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // m is |v| mod 2*pi; map v into [-pi, pi]
  function automatic logic signed [19:0] wrap_fix(input logic [41:0] m, input logic neg);
    logic signed [19:0] ms;
    ms = 20'(m);
    if (ms > ddo_pkg::PI_Q16)
      return neg ? ddo_pkg::TWO_PI_Q16 - ms : ms - ddo_pkg::TWO_PI_Q16;
    return neg ? -ms : ms;
  endfunction

  function automatic logic signed [63:0] rsh(input logic signed [63:0] v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  logic signed [63:0] prod_x, prod_y;
  assign prod_x = 64'(dist_q16) * 64'(cc);
  assign prod_y = 64'(dist_q16) * 64'(cs);

  // reduction source: midpoint (heading + half) or new heading (heading + dang)
  always_comb begin
    if (state == S_POS) wsrc = 48'(heading_acc) + 48'(dang);
    else                wsrc = 48'(heading_acc) + 48'(rsh(ang32, 17));
  end

  assign wmag      = wsrc[47] ? 48'(-wsrc) : 48'(wsrc);
  assign wacc_next = (wacc >= wdiv) ? wacc - wdiv : wacc;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      enable <= 1'b0;
      ldpt <= '0; rdpt <= '0; lapm <= '0; rapm <= '0;
      x_acc <= '0; y_acc <= '0; heading_acc <= '0;
      speed_reg <= '0; turn_rate_reg <= '0;
      out_valid <= 1'b0;
      cstart <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      cstart <= 1'b0;
      dreq.start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          ddo_pkg::REG_ENABLE: enable <= cfg_data[0];
          ddo_pkg::REG_LDPT:   ldpt <= cfg_data;
          ddo_pkg::REG_RDPT:   rdpt <= cfg_data;
          ddo_pkg::REG_LAPM:   lapm <= cfg_data;
          ddo_pkg::REG_RAPM:   rapm <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            lt <= ddo_pkg::clip_ticks(left_ticks);
            rt <= ddo_pkg::clip_ticks(right_ticks);
            dt <= (elapsed_ms == 16'd0) ? 27'd1 : 27'(elapsed_ms) * 27'd1000;
            pose_updated <= 1'b0;
            if (!enable) begin
              state <= S_OUT;
            end else if (cmd == ddo_pkg::CMD_RESET) begin
              x_acc <= '0; y_acc <= '0; heading_acc <= '0;
              pose_updated <= 1'b1;
              state <= S_OUT;
            end else if (ddo_pkg::clip_ticks(left_ticks) == 16'sd0 &&
                         ddo_pkg::clip_ticks(right_ticks) == 16'sd0) begin
              state <= S_OUT;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          dl <= 42'(lt) * $signed({18'd0, ldpt});
          dr <= 42'(rt) * $signed({18'd0, rdpt});
          state <= S_MUL2;
        end
        S_MUL2: begin
          dist_q16 <= 34'(rsh(64'(dl) + 64'(dr), 9));
          dl16 <= 34'(rsh(64'(dl), 8));
          dr16 <= 34'(rsh(64'(dr), 8));
          state <= S_ANG;
        end
        S_ANG: begin
          ang32 <= 64'(dr16) * $signed({40'd0, rapm}) - 64'(dl16) * $signed({40'd0, lapm});
          state <= S_HALF;
        end
        S_HALF: begin
          // full heading change; start reducing heading + half
          dang  <= 42'(rsh(ang32, 16));
          wacc  <= wmag[41:0];
          wneg  <= wsrc[47];
          wdiv  <= ddo_pkg::WRAP_TOP;
          wstep <= 5'(ddo_pkg::WRAP_SHIFT);
          state <= S_WMID;
        end
        S_WMID: begin
          if (wstep == 5'd0) begin
            mid    <= wrap_fix(wacc_next, wneg);
            cstart <= 1'b1;
            state  <= S_CORD;
          end else begin
            wacc  <= wacc_next;
            wdiv  <= wdiv >> 1;
            wstep <= wstep - 5'd1;
          end
        end
        S_CORD: begin
          if (cdone) state <= S_POS;
        end
        S_POS: begin
          x_acc <= ddo_pkg::sat32(64'(x_acc) + rsh(prod_x, 30));
          y_acc <= ddo_pkg::sat32(64'(y_acc) + rsh(prod_y, 30));
          // start reducing heading + dang
          wacc  <= wmag[41:0];
          wneg  <= wsrc[47];
          wdiv  <= ddo_pkg::WRAP_TOP;
          wstep <= 5'(ddo_pkg::WRAP_SHIFT);
          state <= S_WHDG;
        end
        S_WHDG: begin
          if (wstep == 5'd0) begin
            heading_acc <= 19'(wrap_fix(wacc_next, wneg));
            dreq.start <= 1'b1;
            dreq.num <= 64'(dist_q16) * 64'sd1000000;
            dreq.den <= dt;
            state <= S_DIVS;
          end else begin
            wacc  <= wacc_next;
            wdiv  <= wdiv >> 1;
            wstep <= wstep - 5'd1;
          end
        end
        S_DIVS: begin
          if (drsp.done) begin
            speed_reg <= ddo_pkg::sat32(drsp.quo);
            dreq.start <= 1'b1;
            dreq.num <= 64'(dang) * 64'sd1000000;
            state <= S_DIVT;
          end
        end
        S_DIVT: begin
          if (drsp.done) begin
            turn_rate_reg <= ddo_pkg::sat32(drsp.quo);
            pose_updated <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pos_x = x_acc;
  assign pos_y = y_acc;
  assign heading = heading_acc;
  assign speed = speed_reg;
  assign turn_rate = turn_rate_reg;

endmodule

@@ rtl/core/ddo_checker.sv @@
// Port-level checker for the odometry block, bound to the top level.
module ddo_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [18:0] heading
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    (heading <= 19'sd205887) && (heading >= -19'sd205887)) else $error("heading range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .heading(heading)
);

@@ tb/tb_diff_drive_odometry.sv @@
// Self-checking testbench for the differential-drive odometry block.
`timescale 1ns / 100ps

module tb_diff_drive_odometry;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // Configuration port
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = ddo_pkg::REG_ENABLE;
  logic [23:0] cfg_data = '0;

  // Input channel
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = ddo_pkg::CMD_TICKS;
  logic signed [15:0] left_ticks = '0;
  logic signed [15:0] right_ticks = '0;
  logic [15:0]        elapsed_ms = '0;

  // Output channel
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] pos_x, pos_y, speed, turn_rate;
  logic signed [18:0] heading;
  logic               pose_updated;

  diff_drive_odometry uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .left_ticks(left_ticks), .right_ticks(right_ticks), .elapsed_ms(elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading), .speed(speed),
    .turn_rate(turn_rate), .pose_updated(pose_updated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One expected pose/velocity snapshot per input transaction.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [18:0] hdg;
    logic signed [31:0] spd;
    logic signed [31:0] rate;
    logic               upd;
  } pose_t;

  pose_t pose_queue[$];
  int    error_count = 0;

  // Predictor copy of state and configuration
  logic         odo_enable;
  longint       l_dist_tick, r_dist_tick, l_ang_m, r_ang_m;
  longint       x_pos, y_pos, hdg_pos, spd_val, rate_val;

  // Receiver hold-off, counted by its own process
  int  hold_cycles = 0;
  // Sender burst shaping: 0 = bursty, 1 = always offer
  bit  steady_send = 1'b0;

  const longint ATAN_TAB[24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127};

  // Rounding right shift: floor((v + 2^(s-1)) / 2^s)
  function automatic longint rshift_round(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Reduce an angle into [-pi, pi] in Q16
  function automatic longint angle_wrap(longint v);
    longint r;
    r = v % 411775;
    if (r < 0) r += 411775;
    if (r > 205887) r -= 411775;
    return r;
  endfunction

  // Division rounded to nearest, ties away from zero
  function automatic longint quot_round(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  // Rotation-mode CORDIC for cos/sin in Q30
  task automatic sincos_q30(input longint a16, output longint c, output longint s);
    longint z, xr, yr, t;
    bit     flip;
    int     steps;
    z = a16 * 16384;
    xr = 652032874;
    yr = 0;
    flip = 1'b0;
    steps = (ddo_pkg::CORDIC_STEPS > 24) ? 24 : ddo_pkg::CORDIC_STEPS;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1'b1;
    end
    for (int i = 0; i < steps; i++) begin
      if (z >= 0) begin
        t = xr - (yr >>> i); yr = yr + (xr >>> i); z -= ATAN_TAB[i];
      end else begin
        t = xr + (yr >>> i); yr = yr - (xr >>> i); z += ATAN_TAB[i];
      end
      xr = t;
    end
    c = flip ? -xr : xr;
    s = flip ? -yr : yr;
  endtask

  function automatic longint tick_clip(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (ddo_pkg::TICK_BITS - 1)) - 1;
    lo = -(64'sd1 <<< (ddo_pkg::TICK_BITS - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Advance the predicted pose for one transaction and queue the result.
  task automatic predict_pose(input logic c_in, input logic signed [15:0] lt_in,
                              input logic signed [15:0] rt_in, input logic [15:0] ms);
    longint lt, rt, dl, dr, mean_dist, dl16, dr16, ang32, dang, half, mid, cv, sv, dt;
    pose_t  p;
    logic   upd;
    lt = tick_clip(longint'(lt_in));
    rt = tick_clip(longint'(rt_in));
    upd = 1'b0;
    if (odo_enable) begin
      if (c_in == ddo_pkg::CMD_RESET) begin
        x_pos = 0; y_pos = 0; hdg_pos = 0; upd = 1'b1;
      end else if (lt != 0 || rt != 0) begin
        dl = lt * l_dist_tick;
        dr = rt * r_dist_tick;
        mean_dist = rshift_round(dl + dr, 9);
        dl16 = rshift_round(dl, 8);
        dr16 = rshift_round(dr, 8);
        ang32 = dr16 * r_ang_m - dl16 * l_ang_m;
        dang = rshift_round(ang32, 16);
        half = rshift_round(ang32, 17);
        mid = angle_wrap(hdg_pos + half);
        sincos_q30(mid, cv, sv);
        x_pos = clamp32(x_pos + rshift_round(mean_dist * cv, 30));
        y_pos = clamp32(y_pos + rshift_round(mean_dist * sv, 30));
        hdg_pos = angle_wrap(hdg_pos + dang);
        dt = (ms != 0) ? longint'(ms) * 1000 : 1;
        spd_val = clamp32(quot_round(mean_dist * 1000000, dt));
        rate_val = clamp32(quot_round(dang * 1000000, dt));
        upd = 1'b1;
      end
    end
    p.x = x_pos[31:0]; p.y = y_pos[31:0]; p.hdg = hdg_pos[18:0];
    p.spd = spd_val[31:0]; p.rate = rate_val[31:0]; p.upd = upd;
    pose_queue.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Write one register; updates the predictor's copy at the same time.
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      ddo_pkg::REG_ENABLE: odo_enable = val[0];
      ddo_pkg::REG_LDPT:   l_dist_tick = longint'(val);
      ddo_pkg::REG_RDPT:   r_dist_tick = longint'(val);
      ddo_pkg::REG_LAPM:   l_ang_m = longint'(val);
      ddo_pkg::REG_RAPM:   r_ang_m = longint'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_coeffs(input logic [23:0] ld, input logic [23:0] rd,
                            input logic [23:0] la, input logic [23:0] ra);
    write_reg(ddo_pkg::REG_LDPT, ld);
    write_reg(ddo_pkg::REG_RDPT, rd);
    write_reg(ddo_pkg::REG_LAPM, la);
    write_reg(ddo_pkg::REG_RAPM, ra);
  endtask

  // Offer one transaction and wait until it is taken.
  task automatic send_event(input logic c_in, input logic signed [15:0] lt_in,
                            input logic signed [15:0] rt_in, input logic [15:0] ms);
    @(posedge clk);
    in_valid <= 1'b1;
    cmd <= c_in;
    left_ticks <= lt_in;
    right_ticks <= rt_in;
    elapsed_ms <= ms;
    predict_pose(c_in, lt_in, rt_in, ms);
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    // Random gap after some transactions, none in steady mode
    if (!steady_send && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // Wait until every queued result has come back, plus tail latency.
  task automatic drain_results();
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_random_tick(input int mode);
    logic signed [15:0] lt, rt;
    logic [15:0] ms;
    lt = 16'($urandom);
    rt = 16'($urandom);
    if (mode == 1) begin
      lt = 16'($signed($urandom_range(0, 400)) - 200);
      rt = 16'($signed($urandom_range(0, 400)) - 200);
    end
    ms = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
    if ($urandom_range(0, 3) == 0) ms = 16'($urandom_range(1, 50));
    if ($urandom_range(0, 19) == 0) begin
      lt = '0; rt = '0;
    end
    send_event(($urandom_range(0, 24) == 0) ? ddo_pkg::CMD_RESET : ddo_pkg::CMD_TICKS,
               lt, rt, ms);
  endtask

  // Result checker: compares every accepted output with the oldest expectation.
  always @(posedge clk) begin
    pose_t e;
    if (!rst && out_valid && out_ready) begin
      if (pose_queue.size() == 0) begin
        error_count++;
        $display("ERROR %0t: unexpected result transaction", $realtime);
      end else begin
        e = pose_queue.pop_front();
        if (pos_x !== e.x) report_mismatch("pos_x", pos_x, e.x);
        if (pos_y !== e.y) report_mismatch("pos_y", pos_y, e.y);
        if (heading !== e.hdg) report_mismatch("heading", heading, e.hdg);
        if (speed !== e.spd) report_mismatch("speed", speed, e.spd);
        if (turn_rate !== e.rate) report_mismatch("turn_rate", turn_rate, e.rate);
        if (pose_updated !== e.upd) report_mismatch("pose_updated", pose_updated, e.upd);
      end
    end
  end

  // Receiver stall pattern, with a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Disabled block: nothing moves, even a pose reset.
  task automatic test_disabled();
    write_reg(ddo_pkg::REG_ENABLE, 24'd0);
    send_event(ddo_pkg::CMD_TICKS, 16'sd100, -16'sd50, 16'd10);
    send_event(ddo_pkg::CMD_RESET, 16'sd0, 16'sd0, 16'd0);
    drain_results();
  endtask

  // Coefficients zero: update applies but velocities become zero.
  task automatic test_zero_coeffs();
    write_reg(ddo_pkg::REG_ENABLE, 24'd1);
    send_event(ddo_pkg::CMD_TICKS, 16'sd5, 16'sd5, 16'd1);
    drain_results();
  endtask

  // Field extremes, zero ticks, zero time, heading wrap, saturation.
  task automatic test_directed();
    set_coeffs(24'd167772, 24'd167772, 24'd65536, 24'd65536);
    send_event(ddo_pkg::CMD_TICKS, 16'sd1000, 16'sd1000, 16'd100);
    send_event(ddo_pkg::CMD_TICKS, 16'sd0, 16'sd0, 16'd5);
    send_event(ddo_pkg::CMD_TICKS, -16'sd1000, 16'sd1000, 16'd0);
    send_event(ddo_pkg::CMD_TICKS, 16'sd32767, -16'sd32768, 16'd65535);
    send_event(ddo_pkg::CMD_TICKS, -16'sd32768, 16'sd32767, 16'd1);
    send_event(ddo_pkg::CMD_RESET, 16'sd0, 16'sd0, 16'd0);
    drain_results();
    set_coeffs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_event(ddo_pkg::CMD_TICKS, 16'sd32767, 16'sd32767, 16'd0);
    send_event(ddo_pkg::CMD_TICKS, 16'sd32767, 16'sd32767, 16'd0);
    send_event(ddo_pkg::CMD_TICKS, -16'sd32768, 16'sd32767, 16'd0);
    send_event(ddo_pkg::CMD_TICKS, 16'sd1, -16'sd1, 16'd65535);
    send_event(ddo_pkg::CMD_TICKS, -16'sd32768, -16'sd32768, 16'd0);
    send_event(ddo_pkg::CMD_TICKS, -16'sd32768, -16'sd32768, 16'd0);
    send_event(ddo_pkg::CMD_RESET, -16'sd1, 16'sd1, 16'hFFFF);
    drain_results();
    set_coeffs(24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF);
    send_event(ddo_pkg::CMD_TICKS, 16'sd7, 16'sd300, 16'd3);
    send_event(ddo_pkg::CMD_TICKS, 16'sd7, -16'sd300, 16'd3);
    drain_results();
  endtask

  // Long receiver hold-off while the sender keeps offering.
  task automatic test_backpressure();
    set_coeffs(24'd200000, 24'd190000, 24'd300000, 24'd310000);
    steady_send = 1'b1;
    hold_cycles = 2000;
    repeat (20) send_random_tick(1);
    steady_send = 1'b0;
    drain_results();
  endtask

  // Random phases over several coefficient settings.
  task automatic test_random();
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 9) write_reg(ddo_pkg::REG_ENABLE, 24'd0);
      else if (phase == 0) write_reg(ddo_pkg::REG_ENABLE, 24'd1);
      if (phase == 3)
        set_coeffs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      else if (phase == 6)
        set_coeffs(24'd1, 24'd0, 24'd0, 24'd1);
      else
        set_coeffs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
      repeat (150) begin
        steady_send = ($urandom_range(0, 7) == 0);
        send_random_tick($urandom_range(0, 1));
      end
      steady_send = 1'b0;
      drain_results();
    end
    write_reg(ddo_pkg::REG_ENABLE, 24'd1);
  endtask

  initial begin
    odo_enable = 1'b0;
    l_dist_tick = 0; r_dist_tick = 0; l_ang_m = 0; r_ang_m = 0;
    x_pos = 0; y_pos = 0; hdg_pos = 0; spd_val = 0; rate_val = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_disabled();
    test_zero_coeffs();
    test_directed();
    test_backpressure();
    test_random();
    drain_results();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: time for ~1550 items plus stalls, taken several times over
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
